### hw/rtl/assert_macros.svh
// assertion macros used by the rtl of the tanh squash block
// no dependencies; every macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tss_pkg.sv
// shared constants and elaboration-time table functions for the tanh squash block
// no dependencies; used by tanh_squash_scale_round_core
package tss_pkg;

    localparam int LOGIT_W   = 22;
    localparam int SCALE_W   = 16;
    localparam int CAP_W     = 15;
    localparam int SCORE_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_CAP     = 2'd1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd900;
    localparam logic [CAP_W-1:0]   CAP_RESET   = 15'd32767;

    localparam logic [63:0] Q58_ONE = 64'd1 << 58;

    // unsigned q58 product, truncated
    function automatic logic [63:0] tss_q58_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] w;
        w = {64'd0, a} * {64'd0, b};
        return w[121:58];
    endfunction

    // restoring divide, only called while elaborating the table
    function automatic logic [63:0] tss_udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            q   = {q[62:0], 1'b0};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-16/steps) in q58 by taylor series, each term truncated
    function automatic logic [63:0] tss_exp_step(input int steps);
        logic [63:0] term;
        logic [63:0] r;
        term = Q58_ONE;
        r    = Q58_ONE;
        for (int k = 1; k <= 40; k++) begin
            term = tss_udiv64(term << 4, 64'(steps) * 64'(k));
            if ((k % 2) == 1) r = r - term;
            else r = r + term;
        end
        return r;
    endfunction

    // tanh(8*i/steps) as (1-p)/(1+p), p = r^i, rounded half up to frac bits
    function automatic logic [63:0] tss_entry(input int i, input logic [63:0] r, input int frac);
        logic [63:0] p;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] q;
        p = Q58_ONE;
        for (int j = 0; j < i; j++) begin
            p = tss_q58_mul(p, r);
        end
        num = Q58_ONE - p;
        den = Q58_ONE + p;
        rem = num;
        q   = '0;
        for (int b = 0; b <= frac; b++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

endpackage

### hw/rtl/tanh_squash_scale_round_core.sv
// tanh squash, integer scale, round half away from zero and clamp
// depends on tss_pkg (constants, table functions) and assert_macros.svh
// registered stages from input beat to result beat: rom read, interpolate, scale, round
// one beat per cycle when not stalled; the even/odd rom banks give both neighbors in one read
// each stage moves when the next one is empty or moving, so bubbles fill under a stall
// reset: valid bits clear, output_scale = 900, eval_cap = 32767, rom built at elaboration
`include "assert_macros.svh"

module tanh_squash_scale_round_core #(
    parameter int TABLE_STEPS     = 1024,
    parameter int LOGIT_FRAC_BITS = 16,
    parameter int TABLE_FRAC_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [tss_pkg::LOGIT_W-1:0]  logit,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tss_pkg::SCORE_W-1:0]  eval_score,
    input  logic                                cfg_we,
    input  logic [tss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tss_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tss_pkg::*;

    localparam int IS  = LOGIT_FRAC_BITS + 3;           // interpolation fraction bits
    localparam int TS  = IS + TABLE_FRAC_BITS;          // total shift before rounding
    localparam int VW  = TABLE_FRAC_BITS + 1;           // table entry width
    localparam int TW  = VW + IS;                       // interpolant width
    localparam int SW  = SCALE_W + 1;                   // scale magnitude width
    localparam int PW  = TW + SW;                       // scaled product width
    localparam int MW  = PW + 1 - TS;                   // rounded magnitude width
    localparam int IW  = $clog2(TABLE_STEPS + 1);       // table index width
    localparam int NW  = LOGIT_W + IW;                  // |logit| * steps width
    localparam int BD  = TABLE_STEPS / 2 + 1;           // depth of each rom bank
    localparam int AW  = $clog2(BD);
    localparam logic [63:0] EXP_STEP = tss_exp_step(TABLE_STEPS);

    // rom banks: even bank holds v[2j], odd bank v[2j+1] (last entry repeated past the end)
    logic [VW-1:0] even_rom [BD];
    logic [VW-1:0] odd_rom  [BD];

    genvar g;
    generate
        for (g = 0; g < BD; g++)
        begin : g_rom
            localparam int ODD_IDX = (2 * g + 1 > TABLE_STEPS) ? TABLE_STEPS : 2 * g + 1;
            localparam logic [63:0] EVEN_V = tss_entry(2 * g, EXP_STEP, TABLE_FRAC_BITS);
            localparam logic [63:0] ODD_V  = tss_entry(ODD_IDX, EXP_STEP, TABLE_FRAC_BITS);
            assign even_rom[g] = EVEN_V[VW-1:0];
            assign odd_rom[g]  = ODD_V[VW-1:0];
        end
    endgenerate

    // config registers
    logic [SCALE_W-1:0] scale_reg;
    logic [CAP_W-1:0]   cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            cap_reg   <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OUTPUT_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_EVAL_CAP:     cap_reg   <= cfg_data[CAP_W-1:0];
                default:          ;
            endcase
        end
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic en1, en2, en3, en4;

    assign en4      = !out_valid_reg || !out_stall;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    // stage 0: magnitude, table index, bank addresses
    logic              lneg;
    logic [LOGIT_W-1:0] amag;
    logic [NW-1:0]     num;
    logic [NW-1:0]     idx;
    logic              sat;
    logic [IW-1:0]     ieff;
    logic [IS-1:0]     fr;
    logic              sel;
    logic [IW-1:0]     half_idx;
    logic [IW-1:0]     even_sum;
    logic [IW-1:0]     odd_sum;
    logic [AW-1:0]     even_addr;
    logic [AW-1:0]     odd_addr;

    always_comb
    begin
        lneg      = logit[LOGIT_W-1];
        amag      = lneg ? (LOGIT_W'(0) - LOGIT_W'(logit)) : LOGIT_W'(logit);
        num       = NW'(amag) * NW'(TABLE_STEPS);
        idx       = num >> IS;
        sat       = idx >= NW'(TABLE_STEPS);
        ieff      = sat ? IW'(TABLE_STEPS) : idx[IW-1:0];
        fr        = sat ? '0 : num[IS-1:0];
        sel       = ieff[0];
        half_idx  = ieff >> 1;
        even_sum  = half_idx + IW'(sel);
        odd_sum   = half_idx;
        // clamp past the last bank row; only reached with fr forced to zero
        if (even_sum > IW'(BD - 1)) even_sum = IW'(BD - 1);
        if (odd_sum > IW'(BD - 1)) odd_sum = IW'(BD - 1);
        even_addr = even_sum[AW-1:0];
        odd_addr  = odd_sum[AW-1:0];
    end

    // stage 1: registered rom read
    logic [VW-1:0] even_q_reg, odd_q_reg;
    logic [IS-1:0] fr1_reg;
    logic          sel1_reg, neg1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            even_q_reg <= even_rom[even_addr];
            odd_q_reg  <= odd_rom[odd_addr];
            fr1_reg    <= fr;
            sel1_reg   <= sel;
            neg1_reg   <= lneg;
        end
    end

    // stage 2: linear interpolation
    logic [VW-1:0]        v0, v1;
    logic signed [VW:0]   diff;
    logic signed [TW+1:0] slope;
    logic signed [TW+1:0] t_wide;
    logic [TW-1:0]        t_next;
    logic [TW-1:0]        t2_reg;
    logic                 neg2_reg;

    always_comb
    begin
        v0     = sel1_reg ? odd_q_reg : even_q_reg;
        v1     = sel1_reg ? even_q_reg : odd_q_reg;
        diff   = signed'({1'b0, v1}) - signed'({1'b0, v0});
        slope  = (TW+2)'(diff) * signed'((TW+2)'({1'b0, fr1_reg}));
        t_wide = signed'((TW+2)'({v0, {IS{1'b0}}})) + slope;
        t_next = t_wide[TW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            t2_reg   <= t_next;
            neg2_reg <= neg1_reg;
        end
    end

    // stage 3: multiply by |output_scale|
    logic          scale_neg;
    logic [SW-1:0] smag;
    logic [PW-1:0] prod_next;
    logic [PW-1:0] prod3_reg;
    logic          neg3_reg;

    always_comb
    begin
        scale_neg = scale_reg[SCALE_W-1];
        smag      = scale_neg ? (SW'(0) - {1'b1, scale_reg}) : {1'b0, scale_reg};
        prod_next = PW'(t2_reg) * PW'(smag);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            prod3_reg <= prod_next;
            neg3_reg  <= neg2_reg ^ scale_neg;
        end
    end

    // stage 4: round half away from zero, clamp, sign
    logic [PW:0]          rsum;
    logic [MW-1:0]        mag;
    logic [CAP_W-1:0]     magc;
    logic [SCORE_W-1:0]   score_next;
    logic [SCORE_W-1:0]   score_reg;

    always_comb
    begin
        rsum       = {1'b0, prod3_reg} + ((PW+1)'(1) << (TS - 1));
        mag        = rsum[PW:TS];
        magc       = (mag > MW'(cap_reg)) ? cap_reg : mag[CAP_W-1:0];
        score_next = neg3_reg ? (SCORE_W'(0) - SCORE_W'(magc)) : SCORE_W'(magc);
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            score_reg <= score_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) out_valid_reg <= v3_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign eval_score = signed'(score_reg);

    // input only stalls when every stage holds a beat
    `ASSERT_NOW(a_stall_full, in_stall, v1_reg && v2_reg && v3_reg && out_valid_reg, "pipe not full")
    // a held stage-1 beat keeps its rom read data
    `ASSERT_NEXT(a_rom_hold, v1_reg && !en2, $stable(even_q_reg) && $stable(odd_q_reg), "rom data lost")
    // a taken result with nothing behind it leaves the output empty
    `ASSERT_NEXT(a_out_drain, out_valid_reg && !out_stall && !v3_reg, !out_valid_reg, "result repeated")

endmodule
